### sv/imutcf_pkg.sv
// Shared types, widths and the CORDIC arctangent table of the tilt filter.
package imutcf_pkg;

  localparam int RAW_W  = 16;  // raw sensor count width
  localparam int ANG_W  = 18;  // accel angle width in 1/256 degree
  localparam int RATE_W = 17;  // gyro rate width in degrees per second
  localparam int OUT_W  = 32;  // blended angle width
  localparam int DIV_W  = 15;  // gyro divisor width
  localparam int WGT_W  = 9;   // accel weight width
  localparam int TS_W   = 16;  // time step width
  localparam int CRD_W  = 28;  // CORDIC x and y datapath width
  localparam int Z_W    = 25;  // CORDIC angle accumulator width, 2^-16 degree
  localparam int STEP_W = 5;   // index into the 23 entry arctangent table
  localparam int ROOT_W = 24;  // square root result width
  localparam int RAD_W  = 48;  // square root radicand width
  localparam int REM_W  = 26;  // square root remainder width
  localparam int NLANES = 3;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_DIVISOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_WEIGHT = 1'b1;

  typedef struct packed {
    logic                     done;
    logic signed [ANG_W-1:0]  angle;
    logic signed [RATE_W-1:0] rate;
  } lane_res_t;

  // atan(2^-i) in 2^-16 degree, rounded to nearest.
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:  v = 25'sd2949120;
      5'd1:  v = 25'sd1740967;
      5'd2:  v = 25'sd919879;
      5'd3:  v = 25'sd466945;
      5'd4:  v = 25'sd234379;
      5'd5:  v = 25'sd117304;
      5'd6:  v = 25'sd58666;
      5'd7:  v = 25'sd29335;
      5'd8:  v = 25'sd14668;
      5'd9:  v = 25'sd7334;
      5'd10: v = 25'sd3667;
      5'd11: v = 25'sd1833;
      5'd12: v = 25'sd917;
      5'd13: v = 25'sd458;
      5'd14: v = 25'sd229;
      5'd15: v = 25'sd115;
      5'd16: v = 25'sd57;
      5'd17: v = 25'sd29;
      5'd18: v = 25'sd14;
      5'd19: v = 25'sd7;
      5'd20: v = 25'sd4;
      5'd21: v = 25'sd2;
      5'd22: v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage

### sv/imutcf_lane.sv
// One lane: gyro rate divider, hypotenuse square root and CORDIC atan2.
module imutcf_lane #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                hyp_num,
  input  logic signed [imutcf_pkg::RAW_W-1:0] opa,
  input  logic signed [imutcf_pkg::RAW_W-1:0] opb,
  input  logic signed [imutcf_pkg::RAW_W-1:0] opn,
  input  logic signed [imutcf_pkg::RAW_W-1:0] gyro,
  input  logic [imutcf_pkg::DIV_W-1:0]        divisor,
  output imutcf_pkg::lane_res_t               res
);
  import imutcf_pkg::*;

  typedef enum logic [5:0] {
    L_IDLE  = 6'b000001,
    L_SQ    = 6'b000010,
    L_ROOT  = 6'b000100,
    L_CINIT = 6'b001000,
    L_CORD  = 6'b010000,
    L_DONE  = 6'b100000
  } lane_state_t;

  lane_state_t state;

  logic [2*RAW_W-1:0] asq, bsq;
  logic [RAD_W-1:0]   rad;
  logic [REM_W-1:0]   rem;
  logic [ROOT_W-1:0]  root;
  logic [STEP_W-1:0]  rcnt;

  logic [RAW_W-1:0]   dd, dq;
  logic [DIV_W-1:0]   drem, dsor;
  logic               dneg, drun;
  logic [3:0]         dcnt;

  logic signed [CRD_W-1:0] cx, cy;
  logic signed [Z_W-1:0]   cz;
  logic [STEP_W-1:0]       cstep;
  logic                    zero;

  logic [REM_W+1:0] rt, rtrial;
  logic [RAW_W-1:0] dr;
  logic signed [CRD_W-1:0] xs, ys;
  logic signed [Z_W:0]     zr;

  assign rt     = {rem, rad[RAD_W-1 -: 2]};
  assign rtrial = {2'b00, root, 2'b01};
  assign dr     = {drem, dd[RAW_W-1]};
  assign xs     = cx >>> cstep;
  assign ys     = cy >>> cstep;
  assign zr     = {cz[Z_W-1], cz} + (Z_W+1)'(128);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      drun  <= 1'b0;
    end else begin
      case (state)
        L_IDLE: begin
          if (start) begin
            asq   <= (2*RAW_W)'(opa * opa);
            bsq   <= (2*RAW_W)'(opb * opb);
            dneg  <= gyro[RAW_W-1];
            dd    <= gyro[RAW_W-1] ? RAW_W'(-gyro) : gyro;
            dq    <= '0;
            drem  <= '0;
            dsor  <= (divisor == '0) ? DIV_W'(1) : divisor;
            dcnt  <= '0;
            drun  <= 1'b1;
            state <= L_SQ;
          end
        end
        L_SQ: begin
          rad   <= {asq + bsq, 16'h0000};
          rem   <= '0;
          root  <= '0;
          rcnt  <= '0;
          state <= L_ROOT;
        end
        L_ROOT: begin
          if (rt >= rtrial) begin
            rem  <= REM_W'(rt - rtrial);
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= rt[REM_W-1:0];
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          rad  <= {rad[RAD_W-3:0], 2'b00};
          rcnt <= rcnt + 1'b1;
          if (rcnt == STEP_W'(ROOT_W-1)) state <= L_CINIT;
        end
        L_CINIT: begin
          if (hyp_num) begin
            cx <= CRD_W'(512);
            cy <= CRD_W'({1'b0, root});
          end else begin
            cx <= CRD_W'({1'b0, root});
            cy <= CRD_W'($signed({opn, 8'h00}));
          end
          // Only atan2(0, 0) is forced to zero; the hypotenuse lane has a
          // fixed nonzero denominator.
          zero  <= !hyp_num && (root == '0) && (opn == '0);
          cz    <= '0;
          cstep <= '0;
          state <= L_CORD;
        end
        L_CORD: begin
          if (!cy[CRD_W-1]) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + atan_entry(cstep);
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - atan_entry(cstep);
          end
          cstep <= cstep + 1'b1;
          if (cstep == STEP_W'(CORDIC_STEPS-1)) state <= L_DONE;
        end
        L_DONE: state <= L_IDLE;
        default: state <= L_IDLE;
      endcase

      // Restoring division runs alongside the square root.
      if (drun && state != L_IDLE) begin
        if (dr >= {1'b0, dsor}) begin
          drem <= DIV_W'(dr - {1'b0, dsor});
          dq   <= {dq[RAW_W-2:0], 1'b1};
        end else begin
          drem <= dr[DIV_W-1:0];
          dq   <= {dq[RAW_W-2:0], 1'b0};
        end
        dd   <= {dd[RAW_W-2:0], 1'b0};
        dcnt <= dcnt + 1'b1;
        if (dcnt == 4'd15) drun <= 1'b0;
      end
    end
  end

  always_comb begin
    res.done  = (state == L_DONE);
    res.angle = zero ? '0 : ANG_W'(zr >>> 8);
    res.rate  = dneg ? -RATE_W'({1'b0, dq}) : RATE_W'({1'b0, dq});
  end

endmodule

### sv/imutcf_merge.sv
// Merge stage: gyro integration with load and saturation, then weighted blend.
module imutcf_merge (
  input  logic                                        clk,
  input  logic                                        rst,
  input  imutcf_pkg::lane_res_t [imutcf_pkg::NLANES-1:0] res,
  input  logic [imutcf_pkg::TS_W-1:0]                 ts,
  input  logic [imutcf_pkg::WGT_W-1:0]                wgt,
  input  logic                                        out_ready,
  output logic                                        out_valid,
  output logic [3*imutcf_pkg::OUT_W-1:0]              out_data,
  output logic                                        loaded
);
  import imutcf_pkg::*;

  typedef enum logic [4:0] {
    M_IDLE  = 5'b00001,
    M_PROD  = 5'b00010,
    M_INT   = 5'b00100,
    M_BLEND = 5'b01000,
    M_SUM   = 5'b10000
  } merge_state_t;

  merge_state_t state;

  logic signed [ANG_W-1:0]        acc   [NLANES];
  logic signed [RATE_W-1:0]       rate  [NLANES];
  logic signed [OUT_W-1:0]        integ [NLANES];
  logic signed [2*RATE_W-1:0]     gts   [NLANES];
  logic signed [ANG_W+WGT_W:0]    pa    [NLANES];
  logic signed [OUT_W+WGT_W:0]    pg    [NLANES];
  logic [TS_W-1:0]                tsr;
  logic signed [WGT_W:0]          wa, wg;
  logic                           all_zero;

  assign all_zero = (integ[0] == '0) && (integ[1] == '0) && (integ[2] == '0);

  always_ff @(posedge clk) begin
    logic signed [2*RATE_W-1:0] inc;
    logic signed [OUT_W+2:0]    v;
    logic signed [OUT_W+WGT_W+1:0] s;
    if (rst) begin
      state     <= M_IDLE;
      out_valid <= 1'b0;
      loaded    <= 1'b0;
      for (int k = 0; k < NLANES; k++) integ[k] <= '0;
    end else begin
      loaded <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        M_IDLE: begin
          if (res[0].done) begin
            for (int k = 0; k < NLANES; k++) begin
              acc[k]  <= res[k].angle;
              rate[k] <= res[k].rate;
            end
            tsr   <= ts;
            wa    <= (wgt > WGT_W'(256)) ? (WGT_W+1)'(256) : (WGT_W+1)'(wgt);
            state <= M_PROD;
          end
        end
        M_PROD: begin
          wg <= (WGT_W+1)'(256) - wa;
          for (int k = 0; k < NLANES; k++)
            gts[k] <= (2*RATE_W)'(rate[k] * $signed({1'b0, tsr}));
          state <= M_INT;
        end
        M_INT: begin
          for (int k = 0; k < NLANES; k++) begin
            // Truncate toward zero: bias negative products before the shift.
            inc = gts[k][2*RATE_W-1] ? (gts[k] + (2*RATE_W)'(255)) : gts[k];
            inc = inc >>> 8;
            v   = (OUT_W+3)'(integ[k]) + (OUT_W+3)'(inc);
            if (all_zero) integ[k] <= OUT_W'(acc[k]);
            else if (v > (OUT_W+3)'(32'sh7FFFFFFF)) integ[k] <= 32'sh7FFFFFFF;
            else if (v < -(OUT_W+3)'(33'sh080000000)) integ[k] <= 32'sh80000000;
            else integ[k] <= v[OUT_W-1:0];
          end
          state <= M_BLEND;
        end
        M_BLEND: begin
          for (int k = 0; k < NLANES; k++) begin
            pa[k] <= (ANG_W+WGT_W+1)'(wa * acc[k]);
            pg[k] <= (OUT_W+WGT_W+1)'(wg * integ[k]);
          end
          state <= M_SUM;
        end
        M_SUM: begin
          if (!out_valid || out_ready) begin
            for (int k = 0; k < NLANES; k++) begin
              s = (OUT_W+WGT_W+2)'(pa[k]) + (OUT_W+WGT_W+2)'(pg[k])
                  + (OUT_W+WGT_W+2)'(128);
              s = s >>> 8;
              out_data[k*OUT_W +: OUT_W] <= s[OUT_W-1:0];
            end
            out_valid <= 1'b1;
            loaded    <= 1'b1;
            state     <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  ap_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    loaded |-> out_valid) else $error("load without valid result");
  ap_load_from_sum: assert property (@(posedge clk) disable iff (rst)
    loaded |-> $past(state) == M_SUM) else $error("load outside sum step");
  ap_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> !loaded) else $error("result overwritten");

endmodule

### sv/imu_tilt_complementary_filter.sv
// Top level of the accelerometer and gyroscope tilt complementary filter.
// Usage: one sensor sample enters on the s_ channel as a transfer whose tdata
// packs accel x, y, z, gyro x, y, z and the time step. Three lanes then work
// side by side, one per axis: each divides its gyro rate by gyro_divisor and
// finds an accel tilt angle with an iterative square root followed by a CORDIC
// atan2. The merge stage integrates the gyro angles (loading them from the
// accel angles while all three are zero) and blends them with accel_weight.
// One sample is in work at a time: a new sample is taken only once the result
// of the last one is loaded into the output register on the m_ channel. When
// the receiver stalls the result holds there, the next sample is still taken
// and worked, and the merge stage waits for the register to drain. Reset
// clears the integrated angles to zero and sets gyro_divisor to 131 and
// accel_weight to 26. A configuration write takes effect at once, so it
// should be made only while no sample is in work.
module imu_tilt_complementary_filter #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_step (16 b each)
  input  logic [7*imutcf_pkg::RAW_W-1:0]        s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // angle_x, angle_y, angle_z (32 b each)
  output logic [3*imutcf_pkg::OUT_W-1:0]        m_tdata,
  input  logic                                  cfg_we,
  input  logic [imutcf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [imutcf_pkg::DIV_W-1:0]          cfg_data
);
  import imutcf_pkg::*;

  logic [DIV_W-1:0]        gyro_divisor;
  logic [WGT_W-1:0]        accel_weight;
  logic                    busy, start, loaded;
  logic [7*RAW_W-1:0]      sample;
  lane_res_t [NLANES-1:0]  res;
  logic signed [RAW_W-1:0] ax, ay, az;

  assign s_tready = !busy;
  assign ax = sample[0*RAW_W +: RAW_W];
  assign ay = sample[1*RAW_W +: RAW_W];
  assign az = sample[2*RAW_W +: RAW_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_divisor <= DIV_W'(131);
      accel_weight <= WGT_W'(26);
      busy         <= 1'b0;
      start        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GYRO_DIVISOR: gyro_divisor <= cfg_data;
          REG_ACCEL_WEIGHT: accel_weight <= cfg_data[WGT_W-1:0];
          default: ;
        endcase
      end
      start <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) busy <= 1'b1;
      else if (loaded) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) sample <= s_tdata;
  end

  // Lane x: atan2(x, hypot(y,z)); lane y: atan2(y, hypot(x,z));
  // lane z: atan2(hypot(y,z), 2).
  imutcf_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_x (
    .clk, .rst, .start, .hyp_num(1'b0), .opa(ay), .opb(az), .opn(ax),
    .gyro(sample[3*RAW_W +: RAW_W]), .divisor(gyro_divisor), .res(res[0]));
  imutcf_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_y (
    .clk, .rst, .start, .hyp_num(1'b0), .opa(ax), .opb(az), .opn(ay),
    .gyro(sample[4*RAW_W +: RAW_W]), .divisor(gyro_divisor), .res(res[1]));
  imutcf_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_z (
    .clk, .rst, .start, .hyp_num(1'b1), .opa(ay), .opb(az), .opn(az),
    .gyro(sample[5*RAW_W +: RAW_W]), .divisor(gyro_divisor), .res(res[2]));

  imutcf_merge u_merge (
    .clk, .rst, .res, .ts(sample[6*RAW_W +: RAW_W]), .wgt(accel_weight),
    .out_ready(m_tready), .out_valid(m_tvalid), .out_data(m_tdata), .loaded);

  ap_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    res[0].done == res[1].done && res[1].done == res[2].done)
    else $error("lanes finished out of step");
  ap_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    res[0].done |-> busy) else $error("lane result with no sample in work");
  ap_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("second sample taken");

endmodule

### test/imu_tilt_complementary_filter_test.sv
// Self-checking testbench of the tilt complementary filter: directed and random samples.
`timescale 1ns / 100ps

module imu_tilt_complementary_filter_test;
  import imutcf_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int LATENCY = CORDIC_STEPS + 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1450;

  // One sensor sample as it travels on the input stream.
  typedef struct packed {
    logic [15:0] time_step;
    logic signed [15:0] gz, gy, gx, az, ay, ax;
  } sample_t;

  // One row of the directed table. A known expectation is typed in where
  // it is obvious; otherwise the predictor supplies it.
  typedef struct {
    sample_t smp;
    bit known;
    logic signed [31:0] ex, ey, ez;
  } row_t;

  // Timeout guard must be declared before use below.
  // (hold off of the receiver is controlled by the sink_hold flag below)
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7*RAW_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [3*OUT_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GYRO_DIVISOR;
  logic [DIV_W-1:0] cfg_data = '0;

  imu_tilt_complementary_filter #(.CORDIC_STEPS(CORDIC_STEPS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: its own copy of the registers and the integrated angles.
  logic [14:0] divisor_q = 15'd131;
  logic [8:0] weight_q = 9'd26;
  logic signed [31:0] gyro_angle [3];
  logic [95:0] angle_queue [$];

  int errors = 0;
  int idle_cycles = 0;
  bit sink_calm = 1'b0;  // receiver never stalls while set
  bit source_calm = 1'b0;
  bit sink_hold = 1'b0;  // receiver stalls hard while set
  bit watchdog_fired = 1'b0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;  // arithmetic on longint floors
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint hypot_256(longint a, longint b);
    longint unsigned sq;
    sq = a * a + b * b;
    return root_floor(sq << 16);
  endfunction

  function automatic longint tilt_atan2(longint num, longint den);
    longint x = den, y = num, z = 0, nx;
    if (num == 0 && den == 0) return 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += atan_entry(i[4:0]);
      end else begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= atan_entry(i[4:0]);
      end
      x = nx;
    end
    return floor_shift(z + 128, 8);
  endfunction

  // Works out the blended angles of one sample and advances the gyro state.
  function automatic logic [95:0] predict_angles(sample_t s);
    longint acc [3];
    longint rate [3];
    longint div, w, v, hyz;
    logic [95:0] r;
    div = (divisor_q == 0) ? 1 : divisor_q;
    w = (weight_q > 256) ? 256 : weight_q;
    hyz = hypot_256(s.ay, s.az);
    rate[0] = longint'(s.gx) / div;
    rate[1] = longint'(s.gy) / div;
    rate[2] = longint'(s.gz) / div;
    acc[0] = tilt_atan2(longint'(s.ax) * 256, hyz);
    acc[1] = tilt_atan2(longint'(s.ay) * 256, hypot_256(s.ax, s.az));
    acc[2] = tilt_atan2(hyz, 512);
    if (gyro_angle[0] == 0 && gyro_angle[1] == 0 && gyro_angle[2] == 0) begin
      for (int k = 0; k < 3; k++) gyro_angle[k] = 32'(acc[k]);
    end else begin
      for (int k = 0; k < 3; k++) begin
        v = longint'(gyro_angle[k]) + (rate[k] * longint'(s.time_step)) / 256;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        gyro_angle[k] = 32'(v);
      end
    end
    for (int k = 0; k < 3; k++)
      r[32*k +: 32] =
        32'(floor_shift(w * acc[k] + (256 - w) * longint'(gyro_angle[k]) + 128, 8));
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
    errors++;
  endtask

  // Receiver: random stalls, a calm stretch, and a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !sink_hold && (sink_calm || $urandom_range(99) >= 30);
    end
  end

  // Checker: every output transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    logic [95:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (angle_queue.size() == 0) begin
        $display("unexpected result transfer %h", m_tdata);
        errors++;
      end else begin
        want = angle_queue.pop_front();
        if (m_tdata[31:0] !== want[31:0]) report_mismatch("angle_x", m_tdata[31:0], want[31:0]);
        if (m_tdata[63:32] !== want[63:32])
          report_mismatch("angle_y", m_tdata[63:32], want[63:32]);
        if (m_tdata[95:64] !== want[95:64])
          report_mismatch("angle_z", m_tdata[95:64], want[95:64]);
      end
    end
  end

  // Watchdog: counts cycles without any transfer, outside reset and receiver hold-off.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || sink_hold)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !watchdog_fired) begin
      watchdog_fired <= 1'b1;
      $display("imu_tilt_complementary_filter_test failed");
      $finish;
    end
  end

  // Sends one sample; the prediction is queued at the accepting edge. Valid
  // stays high after the transfer so that samples can follow back to back.
  task automatic send_sample(sample_t s, bit known, logic [95:0] typed);
    logic [95:0] p;
    while (!source_calm && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= s;
    do @(posedge clk); while (!s_tready);
    p = predict_angles(s);
    angle_queue.push_back(known ? typed : p);
  endtask

  // Stops offering samples and waits until every result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DIV_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GYRO_DIVISOR) divisor_q = val;
    else weight_q = val[8:0];
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] random_raw();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd0;
      3: return 16'(int'($urandom_range(40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.ax = random_raw(); s.ay = random_raw(); s.az = random_raw();
    s.gx = random_raw(); s.gy = random_raw(); s.gz = random_raw();
    s.time_step = ($urandom_range(7) == 0) ? 16'hffff : 16'($urandom);
    return s;
  endfunction

  row_t rows [$];
  sample_t tmp;

  initial begin
    for (int k = 0; k < 3; k++) gyro_angle[k] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. The first sample after reset is all zero: the x and y
    // accel angles are 0 and the state is loaded from the accel angles.
    tmp = '0;
    rows.push_back('{tmp, 1'b0, 0, 0, 0});
    // Both atan2 arguments zero again on x and y.
    rows.push_back('{tmp, 1'b0, 0, 0, 0});
    // Zero hypotenuse with a nonzero numerator, full scale on x.
    tmp = '{time_step: 16'hffff, gz: 0, gy: 0, gx: 0, az: 0, ay: 0, ax: 16'sh7fff};
    rows.push_back('{tmp, 1'b0, 0, 0, 0});
    tmp = '{time_step: 16'hffff, gz: 16'sh8000, gy: 16'sh7fff, gx: 16'sh8000,
            az: 16'sh8000, ay: 16'sh8000, ax: 16'sh8000};
    rows.push_back('{tmp, 1'b0, 0, 0, 0});
    tmp = '{time_step: 16'hffff, gz: 16'sh7fff, gy: 16'sh8000, gx: 16'sh7fff,
            az: 16'sh7fff, ay: 16'sh7fff, ax: 16'sh7fff};
    rows.push_back('{tmp, 1'b0, 0, 0, 0});
    tmp = '{time_step: 0, gz: 16'sh1234, gy: -5, gx: 7, az: 16384, ay: 0, ax: 0};
    rows.push_back('{tmp, 1'b0, 0, 0, 0});
    for (int i = 0; i < 6; i++) rows.push_back('{random_sample(), 1'b0, 0, 0, 0});
    foreach (rows[i]) send_sample(rows[i].smp, rows[i].known,
                                  {rows[i].ez, rows[i].ey, rows[i].ex});
    drain_results();

    // Zero divisor acts as one and a full weight ignores the gyro; drive the
    // state toward saturation with large rates and the longest time step.
    write_register(REG_GYRO_DIVISOR, 15'd0);
    write_register(REG_ACCEL_WEIGHT, 15'd256);
    tmp = '{time_step: 16'hffff, gz: 16'sh7fff, gy: 16'sh7fff, gx: 16'sh7fff,
            az: 100, ay: 0, ax: 0};
    repeat (8) send_sample(tmp, 1'b0, '0);
    drain_results();
    // Weight above range saturates; then zero weight shows the raw gyro state.
    write_register(REG_ACCEL_WEIGHT, 15'd511);
    tmp.gx = 16'sh8000; tmp.gy = 16'sh8000; tmp.gz = 16'sh8000;
    repeat (4) send_sample(tmp, 1'b0, '0);
    drain_results();
    write_register(REG_ACCEL_WEIGHT, 15'd0);
    write_register(REG_GYRO_DIVISOR, 15'd32767);
    repeat (4) send_sample(random_sample(), 1'b0, '0);
    drain_results();

    // Random phases over several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_register(REG_GYRO_DIVISOR, (ph == 0) ? 15'd1 : 15'($urandom_range(32767)));
      write_register(REG_ACCEL_WEIGHT, (ph == 1) ? 15'd256 : 15'($urandom_range(511)));
      sink_calm = (ph == 2);
      source_calm = (ph == 2);
      if (ph == 3) begin
        // Long receiver hold-off while the sender keeps offering samples.
        fork
          begin
            sink_hold = 1'b1;
            repeat (600) @(posedge clk);
            sink_hold = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
        // In phase 4 the sender pauses once, after 100 samples, until everything has come back.
        if (ph == 4 && i == 100) drain_results();
        send_sample(random_sample(), 1'b0, '0);
      end
      sink_calm = 1'b0;
      source_calm = 1'b0;
      drain_results();
      while (sink_hold) @(posedge clk);
    end

    if (errors == 0) begin
      $display("imu_tilt_complementary_filter_test passed");
    end else begin
      $display("imu_tilt_complementary_filter_test failed");
    end
    $finish;
  end

endmodule

### imu_tilt_complementary_filter.f
sv/imutcf_pkg.sv
sv/imutcf_lane.sv
sv/imutcf_merge.sv
sv/imu_tilt_complementary_filter.sv
test/imu_tilt_complementary_filter_test.sv
